@@ src/x25_address_string_parser_defines.svh @@
// Shared assertion macros. Each expects clk_i and rst_ni in scope.
`ifndef X25_ADDRESS_STRING_PARSER_DEFINES_SVH
`define X25_ADDRESS_STRING_PARSER_DEFINES_SVH

`define X25ASP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define X25ASP_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

@@ src/x25asp_pkg.sv @@
`default_nettype none
package x25asp_pkg;
  localparam int unsigned ADDR_DIGITS = 15;
  localparam int unsigned UDATA_BYTES = 16;
  localparam int unsigned PROTO_BYTES = 4;
  localparam int unsigned ADDR_W = 4 * ADDR_DIGITS;
  localparam int unsigned UDATA_W = 8 * UDATA_BYTES;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_H     = 8'h68;
  localparam logic [7:0] CH_R     = 8'h72;

  typedef struct packed {
    logic [7:0] ch;
    logic       is_nul;
    logic       is_digit;
    logic       is_octal;
    logic       is_comma;
    logic       is_dot;
    logic       is_flag;
    logic       is_rflag;
    logic       is_bsl;
  } item_t;

  typedef struct packed {
    logic [63:0] userdata_high;
    logic [63:0] userdata_low;
    logic [4:0]  userdata_length;
    logic [59:0] address_digits;
    logic [3:0]  address_length;
    logic [31:0] network_id;
    logic        reverse_charge;
    logic        high_priority;
    logic        status;
  } result_t;
endpackage
`default_nettype wire

@@ src/x25asp_front.sv @@
`default_nettype none
module x25asp_front (
  input  wire logic              s_tvalid_i,
  output logic                   s_tready_o,
  input  wire logic [7:0]        s_tdata_i,
  input  wire logic              q_full_i,
  output logic                   q_push_o,
  output x25asp_pkg::item_t      q_item_o
);
  import x25asp_pkg::*;

  logic [7:0] ch;

  assign ch         = s_tdata_i;
  assign s_tready_o = !q_full_i;
  assign q_push_o   = s_tvalid_i && !q_full_i;

  always_comb begin
    q_item_o.ch       = ch;
    q_item_o.is_nul   = (ch == 8'h00);
    q_item_o.is_digit = ch inside {[CH_ZERO:CH_NINE]};
    q_item_o.is_octal = ch inside {[CH_ZERO:CH_SEVEN]};
    q_item_o.is_comma = (ch == CH_COMMA);
    q_item_o.is_dot   = ch inside {CH_DOT, CH_COLON};
    q_item_o.is_flag  = ch inside {CH_P, CH_H, CH_R};
    q_item_o.is_rflag = (ch == CH_R);
    q_item_o.is_bsl   = (ch == CH_BSL);
  end
endmodule
`default_nettype wire

@@ src/x25asp_queue.sv @@
`default_nettype none
`include "x25_address_string_parser_defines.svh"
module x25asp_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire x25asp_pkg::item_t item_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output logic                   valid_o,
  output x25asp_pkg::item_t      item_o
);
  import x25asp_pkg::*;

  item_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push_i) begin
      wptr_d = (wptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= item_i;
    end
  end

  `X25ASP_ASSERT_NEVER(q_no_overflow, push_i && !pop_i && full_o, "queue write while full")
  `X25ASP_ASSERT(q_count_up, (push_i && !pop_i) |=> (count_q == $past(count_q) + 1'b1), "queue count did not rise")
endmodule
`default_nettype wire

@@ src/x25asp_back.sv @@
`default_nettype none
`include "x25_address_string_parser_defines.svh"
module x25asp_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              q_valid_i,
  input  wire x25asp_pkg::item_t q_item_i,
  output logic                   q_pop_o,
  output logic                   m_tvalid_o,
  input  wire logic              m_tready_i,
  output x25asp_pkg::result_t    m_result_o
);
  import x25asp_pkg::*;

  localparam logic [2:0] PH_START      = 3'd0;
  localparam logic [2:0] PH_FLAGS      = 3'd1;
  localparam logic [2:0] PH_ADDR_FIRST = 3'd2;
  localparam logic [2:0] PH_ADDR       = 3'd3;
  localparam logic [2:0] PH_UDATA      = 3'd4;
  localparam logic [2:0] PH_PROTO      = 3'd5;

  localparam logic [1:0] ESC_NONE = 2'd0;
  localparam logic [1:0] ESC_BSL  = 2'd1;
  localparam logic [1:0] ESC_ONE  = 2'd2;
  localparam logic [1:0] ESC_TWO  = 2'd3;

  logic [2:0]         phase_q, phase_d;
  logic               err_q, err_d;
  logic [1:0]         flags_q, flags_d;
  logic               have_q, have_d;
  logic               need_q, need_d;
  logic [31:0]        acc_q, acc_d;
  logic [ADDR_W-1:0]  addr_q, addr_d;
  logic [3:0]         acnt_q, acnt_d;
  logic [UDATA_W-1:0] ud_q, ud_d;
  logic [4:0]         ucnt_q, ucnt_d;
  logic [4:0]         widx_q, widx_d;
  logic [1:0]         esc_q, esc_d;
  logic [5:0]         ev_q, ev_d;
  logic               out_valid_q, out_valid_d;
  result_t            out_res_q, res;

  logic       pop, emit, bad, consumed, to_addr, append;
  logic [4:0] limit;
  item_t      it;

  function automatic logic [UDATA_W-1:0] put_byte(input logic [UDATA_W-1:0] s,
                                                  input logic [4:0] w,
                                                  input logic [7:0] v);
    logic [UDATA_W-1:0] r;
    logic [3:0]         slot;
    r    = s;
    slot = 4'(w - 5'd1);
    if (w != 5'd0 && w <= 5'(UDATA_BYTES)) begin
      r[slot*8 +: 8] = v;
    end
    return r;
  endfunction

  assign it      = q_item_i;
  assign pop     = q_valid_i && (!q_item_i.is_nul || !out_valid_q || m_tready_i);
  assign q_pop_o = pop;

  always_comb begin
    phase_d = phase_q;
    err_d   = err_q;
    flags_d = flags_q;
    have_d  = have_q;
    need_d  = need_q;
    acc_d   = acc_q;
    addr_d  = addr_q;
    acnt_d  = acnt_q;
    ud_d    = ud_q;
    ucnt_d  = ucnt_q;
    widx_d  = widx_q;
    esc_d   = esc_q;
    ev_d    = ev_q;
    emit     = 1'b0;
    bad      = 1'b0;
    consumed = 1'b0;
    to_addr  = 1'b0;
    append   = 1'b0;
    limit    = 5'(UDATA_BYTES);

    if (pop) begin
      if (err_q) begin
        if (it.is_nul) begin
          emit = 1'b1;
          bad  = 1'b1;
        end
      end else begin
        if ((phase_q == PH_UDATA || phase_q == PH_PROTO) && esc_q != ESC_NONE) begin
          case (esc_q)
            ESC_BSL: begin
              if (it.is_octal) begin
                ev_d     = {3'b000, it.ch[2:0]};
                esc_d    = ESC_ONE;
                consumed = 1'b1;
              end else begin
                ud_d = put_byte(ud_d, widx_q, CH_BSL);
              end
            end
            ESC_ONE: begin
              if (it.is_octal) begin
                ev_d     = {ev_q[2:0], it.ch[2:0]};
                esc_d    = ESC_TWO;
                consumed = 1'b1;
              end else begin
                ud_d = put_byte(ud_d, widx_q, 8'(ev_q));
              end
            end
            default: begin
              if (it.is_octal && !ev_q[5]) begin
                ud_d     = put_byte(ud_d, widx_q, {ev_q[4:0], it.ch[2:0]});
                consumed = 1'b1;
              end else begin
                ud_d = put_byte(ud_d, widx_q, 8'(ev_q));
              end
            end
          endcase
          if (!consumed || esc_q == ESC_TWO) begin
            esc_d = ESC_NONE;
            ev_d  = '0;
          end
        end

        if (!consumed) begin
          case (phase_q)
            PH_START: begin
              if (it.is_nul) begin
                emit = 1'b1;
                bad  = 1'b1;
              end else if (it.is_flag) begin
                flags_d = flags_q | (it.is_rflag ? 2'b10 : 2'b01);
                phase_d = PH_FLAGS;
              end else begin
                phase_d = PH_ADDR;
                to_addr = 1'b1;
              end
            end
            PH_FLAGS: begin
              if (it.is_flag) begin
                flags_d = flags_q | (it.is_rflag ? 2'b10 : 2'b01);
              end else if (it.is_comma) begin
                phase_d = PH_ADDR_FIRST;
              end else if (it.is_nul) begin
                emit = 1'b1;
                bad  = 1'b1;
              end else begin
                err_d = 1'b1;
              end
            end
            PH_ADDR_FIRST: begin
              if (it.is_nul) begin
                emit = 1'b1;
                bad  = 1'b1;
              end else begin
                phase_d = PH_ADDR;
                to_addr = 1'b1;
              end
            end
            PH_ADDR: begin
              to_addr = 1'b1;
            end
            PH_UDATA, PH_PROTO: begin
              if (it.is_nul) begin
                emit = 1'b1;
              end else if (it.is_comma) begin
                if (phase_q == PH_UDATA) begin
                  phase_d = PH_PROTO;
                  widx_d  = '0;
                end else begin
                  err_d = 1'b1;
                end
              end else begin
                if (phase_q == PH_PROTO && ucnt_q != 5'd0) begin
                  limit = 5'(PROTO_BYTES);
                end
                if (widx_q >= limit) begin
                  err_d = 1'b1;
                end else begin
                  widx_d = widx_q + 5'd1;
                  if (phase_q == PH_UDATA) begin
                    ucnt_d = ucnt_q + 5'd1;
                  end
                  if (it.is_bsl) begin
                    esc_d = ESC_BSL;
                  end else begin
                    ud_d = put_byte(ud_d, widx_d, it.ch);
                  end
                end
              end
            end
            default: begin
              if (it.is_nul) begin
                emit = 1'b1;
                bad  = 1'b1;
              end else begin
                err_d = 1'b1;
              end
            end
          endcase
        end

        if (to_addr) begin
          if (it.is_nul) begin
            emit = 1'b1;
            bad  = need_q;
          end else if (need_q) begin
            if (!it.is_digit) begin
              err_d = 1'b1;
            end else begin
              need_d = 1'b0;
              append = 1'b1;
            end
          end else if (it.is_comma) begin
            phase_d = PH_UDATA;
            widx_d  = 5'(PROTO_BYTES);
            ucnt_d  = '0;
          end else if (it.is_dot) begin
            if (have_q) begin
              err_d = 1'b1;
            end else begin
              addr_d = '0;
              acnt_d = '0;
              have_d = 1'b1;
              need_d = 1'b1;
            end
          end else if (!it.is_digit) begin
            err_d = 1'b1;
          end else begin
            append = 1'b1;
          end
          if (append) begin
            if (acnt_q >= 4'(ADDR_DIGITS)) begin
              err_d = 1'b1;
            end else begin
              addr_d[acnt_q*4 +: 4] = it.ch[3:0];
              acnt_d = acnt_q + 4'd1;
              if (!have_q) begin
                acc_d = (acc_q << 3) + (acc_q << 1) + 32'(it.ch[3:0]);
              end
            end
          end
        end
      end
    end

    res = '0;
    res.status = bad;
    if (!bad) begin
      res.high_priority   = flags_d[0];
      res.reverse_charge  = flags_d[1];
      res.network_id      = have_d ? acc_d : 32'd0;
      res.address_length  = acnt_d;
      res.address_digits  = 60'(addr_d);
      res.userdata_low    = ud_d[63:0];
      res.userdata_high   = 64'(ud_d >> 64);
      if (phase_d == PH_UDATA) begin
        res.userdata_length = (ucnt_d != 5'd0) ? 5'(PROTO_BYTES) + ucnt_d : 5'd0;
      end else if (phase_d == PH_PROTO) begin
        res.userdata_length = (ucnt_d != 5'd0) ? 5'(PROTO_BYTES) + ucnt_d : widx_d;
      end
    end

    if (emit) begin
      phase_d = PH_START;
      err_d   = 1'b0;
      flags_d = '0;
      have_d  = 1'b0;
      need_d  = 1'b0;
      acc_d   = '0;
      addr_d  = '0;
      acnt_d  = '0;
      ud_d    = '0;
      ucnt_d  = '0;
      widx_d  = '0;
      esc_d   = ESC_NONE;
      ev_d    = '0;
    end

    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (m_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_START;
      err_q       <= 1'b0;
      flags_q     <= '0;
      have_q      <= 1'b0;
      need_q      <= 1'b0;
      acc_q       <= '0;
      addr_q      <= '0;
      acnt_q      <= '0;
      ud_q        <= '0;
      ucnt_q      <= '0;
      widx_q      <= '0;
      esc_q       <= ESC_NONE;
      ev_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      err_q       <= err_d;
      flags_q     <= flags_d;
      have_q      <= have_d;
      need_q      <= need_d;
      acc_q       <= acc_d;
      addr_q      <= addr_d;
      acnt_q      <= acnt_d;
      ud_q        <= ud_d;
      ucnt_q      <= ucnt_d;
      widx_q      <= widx_d;
      esc_q       <= esc_d;
      ev_q        <= ev_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_res_q <= res;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_result_o = out_res_q;

  `X25ASP_ASSERT(b_clear_after_result, emit |=> (phase_q == PH_START && !err_q && acnt_q == 4'd0), "state not cleared after result")
  `X25ASP_ASSERT(b_escape_in_data, (esc_q != ESC_NONE) |-> (phase_q == PH_UDATA || phase_q == PH_PROTO), "escape pending outside data")
  `X25ASP_ASSERT(b_udata_index, (phase_q == PH_UDATA) |-> (widx_q >= 5'(PROTO_BYTES)), "user data index below protocol area")
endmodule
`default_nettype wire

@@ src/x25_address_string_parser.sv @@
// Parses an X.25 address string of the form [flags,]address[,userdata][,protocol], one
// character per request on the input stream; a zero byte ends the string and yields one
// result request carrying the status, flags, network id, address digits and user data.
// The block takes one character every cycle while the queue has room: the parser back end
// finishes each character as it pops it from a two-entry queue behind the classifying
// front end. A result is written to an output register once its zero byte is popped, and
// is held there; the back end waits only when another zero byte arrives while a
// result is still untaken, and the input keeps filling the queue until it is full.
`default_nettype none
module x25_address_string_parser (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  wire logic [7:0]   s_axis_tdata_i,   // char_in[7:0]
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  output logic [231:0]      m_axis_tdata_o    // status, high_priority, reverse_charge,
                                              // network_id[31:0], address_length[3:0],
                                              // address_digits[59:0], userdata_length[4:0],
                                              // userdata_low[63:0], userdata_high[63:0]
);
  import x25asp_pkg::*;

  logic    q_full, q_push, q_valid, q_pop;
  item_t   q_in, q_out;
  result_t result;

  x25asp_front u_front (
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .s_tdata_i  (s_axis_tdata_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_item_o   (q_in)
  );

  x25asp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_out)
  );

  x25asp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_item_i   (q_out),
    .q_pop_o    (q_pop),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_result_o (result)
  );

  assign m_axis_tdata_o = result;
endmodule
`default_nettype wire
